// ===== rtl/core/scrl_pkg.sv =====
`default_nettype none

package scrl_pkg;

  // Length clamp and reset values of the configuration registers
  localparam logic [6:0]  MAX_REG_BITS   = 7'd64;
  localparam logic [6:0]  REG_LEN_RST    = 7'd34;
  localparam logic [63:0] INIT_VALUE_RST = 64'h0000_0000_0FFF_FFFF;

  // Configuration register indexes
  localparam logic CFG_REG_LENGTH = 1'b0;
  localparam logic CFG_INIT_VALUE = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_SET   = 2'd1,
    REQ_LOAD  = 2'd2,
    REQ_OTHER = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_RST_LO = 4'd1,
    PH_RST_HI = 4'd2,
    PH_SH_LO  = 4'd3,
    PH_SH_HI  = 4'd4,
    PH_RB_LO  = 4'd5,
    PH_RB_HI  = 4'd6,
    PH_RB_SMP = 4'd7,
    PH_LAT_LO = 4'd8,
    PH_LAT_HI = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_OK     = 3'd1,
    ST_VERIFY = 3'd2,
    ST_OFFSET = 3'd3,
    ST_BUSY   = 3'd4
  } status_t;

  typedef struct packed {
    req_t       req_type;
    logic [5:0] bit_offset;
    logic       bit_value;
    logic       data_out_level;
  } item_t;

  typedef struct packed {
    logic        reset_pin;
    logic        strobe_pin;
    logic        data_in_pin;
    logic        output_enable_pin;
    logic        busy_res;
    status_t     status;
    logic [63:0] shadow_value;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/serial_config_register_loader.sv =====
// Two register stages: an accepted item waits in the input hold register, then the result register.
// One item per cycle unless m_tready stalls; each item advances the pin sequencer by one step.
// A full load takes 2 + 5*L + 2 items for register length L when the readback matches.
// Reset (rst, synchronous, active high) empties both registers, idles the sequencer,
// drives reset pin high with strobe and data low, and restores length 34 and shadow 0x0FFFFFFF.
`default_nettype none

module serial_config_register_loader (
  input  wire         clk,
  input  wire         rst,
  // Input items
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,  // bit_offset[5:0], bit_value[6], data_out_level[7]
  input  wire  [1:0]  s_tuser,  // req_type[1:0]
  // Result items
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [71:0] m_tdata,  // reset_pin[0], strobe_pin[1], data_in_pin[2],
                                // output_enable_pin[3], busy_res[4], status[7:5],
                                // shadow_value[71:8]
  // Configuration writes
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [63:0] cfg_data
);

  logic               advance;
  logic               held_valid;
  scrl_pkg::item_t    in_item;
  scrl_pkg::item_t    held_item;
  scrl_pkg::res_t     res;
  logic [6:0]         reg_length;
  logic [63:0]        init_value;

  // Unpack input item
  always_comb begin
    in_item.req_type       = scrl_pkg::req_t'(s_tuser);
    in_item.bit_offset     = s_tdata[5:0];
    in_item.bit_value      = s_tdata[6];
    in_item.data_out_level = s_tdata[7];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_length <= scrl_pkg::REG_LEN_RST;
      init_value <= scrl_pkg::INIT_VALUE_RST;
    end else if (cfg_we) begin
      if (cfg_index == scrl_pkg::CFG_REG_LENGTH) begin
        reg_length <= cfg_data[6:0];
      end else begin
        init_value <= cfg_data;
      end
    end
  end

  // Result register frees up when empty or being taken
  assign advance = !m_tvalid || m_tready;

  scrl_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  scrl_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .fire       (held_valid && advance),
    .item       (held_item),
    .reg_length (reg_length),
    .init_value (init_value),
    .res        (res)
  );

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= held_valid;
    end
  end

  // Pack result item
  always_ff @(posedge clk) begin
    if (held_valid && advance) begin
      m_tdata <= {res.shadow_value, res.status, res.busy_res, res.output_enable_pin,
                  res.data_in_pin, res.strobe_pin, res.reset_pin};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scrl_in_stage.sv =====
`default_nettype none

module scrl_in_stage (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire scrl_pkg::item_t in_item,
  input  wire                  advance,
  output logic                 held_valid,
  output scrl_pkg::item_t      held_item
);

  // Take a new item when empty or when the held one moves on this cycle
  assign in_ready = !held_valid || advance;

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/scrl_seq.sv =====
`default_nettype none

module scrl_seq (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  fire,
  input  wire scrl_pkg::item_t item,
  input  wire [6:0]            reg_length,
  input  wire [63:0]           init_value,
  output scrl_pkg::res_t       res
);

  scrl_pkg::phase_t phase, phase_next;
  logic [63:0]      shadow_reg, shadow_reg_next;
  logic [63:0]      readback_acc, readback_acc_next;
  logic [5:0]       bit_index, bit_index_next;
  logic             initial_load_flag, initial_load_flag_next;
  logic             enable_flag, enable_flag_next;
  logic             pin_reset, pin_reset_next;
  logic             pin_strobe, pin_strobe_next;
  logic             pin_data, pin_data_next;
  scrl_pkg::status_t step_status;
  scrl_pkg::status_t status;

  logic [6:0]  eff_len;
  logic [6:0]  eff_len_m1_full;
  logic [5:0]  len_m1;
  logic [63:0] set_value;
  logic [63:0] acc_sampled;

  // Clamp length to 1..MAX_REG_BITS
  always_comb begin
    if (reg_length == 7'd0) begin
      eff_len = 7'd1;
    end else if (reg_length > scrl_pkg::MAX_REG_BITS) begin
      eff_len = scrl_pkg::MAX_REG_BITS;
    end else begin
      eff_len = reg_length;
    end
  end
  assign eff_len_m1_full = eff_len - 7'd1;
  assign len_m1          = eff_len_m1_full[5:0];

  // Shadow with the requested bit applied
  always_comb begin
    set_value = shadow_reg;
    set_value[item.bit_offset] = item.bit_value;
  end

  // Readback with the current sample merged in
  always_comb begin
    acc_sampled = readback_acc;
    acc_sampled[bit_index] = readback_acc[bit_index] | item.data_out_level;
  end

  // Sequencer step, set-bit and initial load handling
  always_comb begin
    phase_next             = phase;
    shadow_reg_next        = shadow_reg;
    readback_acc_next      = readback_acc;
    bit_index_next         = bit_index;
    initial_load_flag_next = initial_load_flag;
    enable_flag_next       = enable_flag;
    pin_reset_next         = pin_reset;
    pin_strobe_next        = pin_strobe;
    pin_data_next          = pin_data;
    step_status            = scrl_pkg::ST_NONE;
    status                 = scrl_pkg::ST_NONE;

    if (phase != scrl_pkg::PH_IDLE) begin
      case (phase)
        scrl_pkg::PH_RST_LO: begin
          pin_reset_next = 1'b0;
          phase_next     = scrl_pkg::PH_RST_HI;
        end
        scrl_pkg::PH_RST_HI: begin
          pin_reset_next = 1'b1;
          bit_index_next = len_m1;
          phase_next     = scrl_pkg::PH_SH_LO;
        end
        scrl_pkg::PH_SH_LO: begin
          pin_strobe_next = 1'b0;
          pin_data_next   = shadow_reg[bit_index];
          phase_next      = scrl_pkg::PH_SH_HI;
        end
        scrl_pkg::PH_SH_HI: begin
          pin_strobe_next = 1'b1;
          if (bit_index == 6'd0) begin
            bit_index_next    = len_m1;
            readback_acc_next = '0;
            phase_next        = scrl_pkg::PH_RB_LO;
          end else begin
            bit_index_next = bit_index - 6'd1;
            phase_next     = scrl_pkg::PH_SH_LO;
          end
        end
        scrl_pkg::PH_RB_LO: begin
          pin_strobe_next = 1'b0;
          phase_next      = scrl_pkg::PH_RB_HI;
        end
        scrl_pkg::PH_RB_HI: begin
          pin_strobe_next = 1'b1;
          phase_next      = scrl_pkg::PH_RB_SMP;
        end
        scrl_pkg::PH_RB_SMP: begin
          readback_acc_next = acc_sampled;
          if (bit_index == 6'd0) begin
            if (acc_sampled != shadow_reg) begin
              step_status = scrl_pkg::ST_VERIFY;
              phase_next  = scrl_pkg::PH_IDLE;
            end else begin
              phase_next = scrl_pkg::PH_LAT_LO;
            end
          end else begin
            bit_index_next = bit_index - 6'd1;
            phase_next     = scrl_pkg::PH_RB_LO;
          end
        end
        scrl_pkg::PH_LAT_LO: begin
          pin_strobe_next = 1'b0;
          phase_next      = scrl_pkg::PH_LAT_HI;
        end
        scrl_pkg::PH_LAT_HI: begin
          pin_strobe_next = 1'b1;
          if (initial_load_flag) begin
            enable_flag_next = 1'b1;
          end
          step_status = scrl_pkg::ST_OK;
          phase_next  = scrl_pkg::PH_IDLE;
        end
        default: begin
          phase_next = scrl_pkg::PH_IDLE;
        end
      endcase
      // A request during a load is dropped; it reports busy unless the load finishes now
      if (step_status != scrl_pkg::ST_NONE) begin
        status = step_status;
      end else if (item.req_type == scrl_pkg::REQ_SET ||
                   item.req_type == scrl_pkg::REQ_LOAD) begin
        status = scrl_pkg::ST_BUSY;
      end
    end else if (item.req_type == scrl_pkg::REQ_SET) begin
      if ({1'b0, item.bit_offset} >= eff_len) begin
        status = scrl_pkg::ST_OFFSET;
      end else if (set_value == shadow_reg) begin
        status = scrl_pkg::ST_OK;
      end else begin
        // Start a load and take its first step at once
        shadow_reg_next        = set_value;
        initial_load_flag_next = 1'b0;
        pin_reset_next         = 1'b0;
        phase_next             = scrl_pkg::PH_RST_HI;
      end
    end else if (item.req_type == scrl_pkg::REQ_LOAD) begin
      shadow_reg_next        = init_value;
      initial_load_flag_next = 1'b1;
      pin_reset_next         = 1'b0;
      phase_next             = scrl_pkg::PH_RST_HI;
    end
  end

  // Advance state on each item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= scrl_pkg::PH_IDLE;
      shadow_reg        <= scrl_pkg::INIT_VALUE_RST;
      readback_acc      <= '0;
      bit_index         <= '0;
      initial_load_flag <= 1'b0;
      enable_flag       <= 1'b0;
      pin_reset         <= 1'b1;
      pin_strobe        <= 1'b0;
      pin_data          <= 1'b0;
    end else if (fire) begin
      phase             <= phase_next;
      shadow_reg        <= shadow_reg_next;
      readback_acc      <= readback_acc_next;
      bit_index         <= bit_index_next;
      initial_load_flag <= initial_load_flag_next;
      enable_flag       <= enable_flag_next;
      pin_reset         <= pin_reset_next;
      pin_strobe        <= pin_strobe_next;
      pin_data          <= pin_data_next;
    end
  end

  // Result reflects the state after this step
  always_comb begin
    res.reset_pin         = pin_reset_next;
    res.strobe_pin        = pin_strobe_next;
    res.data_in_pin       = pin_data_next;
    res.output_enable_pin = enable_flag_next;
    res.busy_res          = (phase_next != scrl_pkg::PH_IDLE);
    res.status            = status;
    res.shadow_value      = shadow_reg_next;
  end

`ifndef NO_ASSERTIONS
  // Output enable only ever rises outside reset
  a_enable_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(enable_flag))
    else $error("output enable dropped");

  // Device reset is low exactly while waiting to release it
  a_reset_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == scrl_pkg::PH_RST_HI) == !pin_reset)
    else $error("reset pin out of step with phase");

  // A verify error always ends the load
  a_verify_idle: assert property (@(posedge clk) disable iff (rst)
    fire && step_status == scrl_pkg::ST_VERIFY |=> phase == scrl_pkg::PH_IDLE)
    else $error("load continued after verify error");
`endif

endmodule

`default_nettype wire
